// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/sism_pkg.sv -----
// ----------------------------------------------------------------------------
// sism_pkg
// Shared types and constants of the sorted interval set merge unit.
// ----------------------------------------------------------------------------
package sism_pkg;

  // Default table depth
  localparam int CAPACITY_DEF = 64;

  // Fixed field widths
  localparam int SEQ_W  = 16;
  localparam int POS_W  = 31;
  localparam int HELD_W = 7;
  localparam int ENTRY_W = SEQ_W + 2 * POS_W;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_RANGE   = 2'd2,
    ST_NO_NEXT = 2'd3
  } status_t;

  // One stored interval
  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [POS_W-1:0] start;
    logic [POS_W-1:0] stop;
  } entry_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic    load_new;     // capture the incoming item
    logic    set_status;   // update the status register
    status_t status_code;
    logic    cursor_inc;   // step the read cursor
    logic    pass_init;    // start a rewrite pass
    logic    rd_old;       // read table at the pass read index
    logic    feed_new;     // push the new interval into the merge stage
    logic    feed_old;     // push the entry just read into the merge stage
    logic    flush;        // write the last merged entry, update count
    logic    rd_cursor;    // read table at the cursor
    logic    load_out;     // fill the result register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic func;            // captured item is an advance
    logic range_bad;       // start after stop
    logic full;            // table holds CAPACITY entries
    logic can_advance;     // cursor has a next entry
    logic pick_new;        // new interval goes into the stream now
    logic rd_more;         // old entries still to be read
    logic out_free;        // result register may be loaded
  } stat_t;

endpackage

// ----- design/sism_ram.sv -----
// ----------------------------------------------------------------------------
// sism_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sism_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; data holds while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/sism_ctrl.sv -----
// ----------------------------------------------------------------------------
// sism_ctrl
// Controller: sequences decode, the rewrite pass and the result load.
// ----------------------------------------------------------------------------
module sism_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  sism_pkg::stat_t stat,
  output sism_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_PROC,
    S_OUT_RD,
    S_OUT_WAIT
  } state_t;

  state_t state, state_next;

  // Next state and command decode
  always_comb begin
    state_next      = state;
    cmd             = '0;
    cmd.status_code = sism_pkg::ST_OK;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_new = 1'b1;
          state_next   = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.set_status = 1'b1;
        state_next     = S_OUT_RD;
        priority if (stat.func) begin
          if (stat.can_advance) begin
            cmd.cursor_inc  = 1'b1;
            cmd.status_code = sism_pkg::ST_OK;
          end else begin
            cmd.status_code = sism_pkg::ST_NO_NEXT;
          end
        end else if (stat.range_bad) begin
          cmd.status_code = sism_pkg::ST_RANGE;
        end else if (stat.full) begin
          cmd.status_code = sism_pkg::ST_FULL;
        end else begin
          cmd.status_code = sism_pkg::ST_OK;
          cmd.pass_init   = 1'b1;
          state_next      = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_old = 1'b1;
        state_next = S_PROC;
      end
      S_PROC: begin
        priority if (stat.pick_new) begin
          cmd.feed_new = 1'b1;
        end else if (stat.rd_more) begin
          cmd.feed_old = 1'b1;
          state_next   = S_READ;
        end else begin
          cmd.flush  = 1'b1;
          state_next = S_OUT_RD;
        end
      end
      S_OUT_RD: begin
        cmd.rd_cursor = 1'b1;
        state_next    = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and registered stall
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_stall <= 1'b0;
    end else begin
      state    <= state_next;
      in_stall <= (state_next != S_IDLE);
    end
  end

endmodule

// ----- design/sism_dpath.sv -----
// ----------------------------------------------------------------------------
// sism_dpath
// Datapath: interval table, merge stage, cursor and result register.
// ----------------------------------------------------------------------------
module sism_dpath #(
  parameter int CAPACITY = sism_pkg::CAPACITY_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  sism_pkg::cmd_t               cmd,
  output sism_pkg::stat_t              stat,
  input  logic                         func,
  input  logic [sism_pkg::SEQ_W-1:0]   seq_id,
  input  logic [sism_pkg::POS_W-1:0]   start_pos,
  input  logic [sism_pkg::POS_W-1:0]   stop_pos,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   status,
  output logic [sism_pkg::HELD_W-1:0]  entries_held,
  output logic                         cur_valid,
  output logic [sism_pkg::SEQ_W-1:0]   cur_seq,
  output logic [sism_pkg::POS_W-1:0]   cur_start,
  output logic [sism_pkg::POS_W-1:0]   cur_stop
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  // Captured item
  sism_pkg::entry_t new_ent;
  logic             new_func;

  // Table state
  logic [CW-1:0]    count;
  logic [AW-1:0]    cursor;
  sism_pkg::status_t status_q;

  // Rewrite pass state
  logic [CW-1:0]    old_cnt;
  logic [CW-1:0]    rd_idx;
  logic [CW-1:0]    wr_idx;
  logic             inserted;
  sism_pkg::entry_t acc;
  logic             acc_valid;

  // Table memory
  logic [sism_pkg::ENTRY_W-1:0] rd_raw;
  sism_pkg::entry_t             rd_ent;
  sism_pkg::entry_t             feed_ent;
  logic                         feeding;
  logic                         can_merge;
  logic                         emit;
  logic                         ram_wr_en;
  logic                         ram_rd_en;
  logic [AW-1:0]                ram_rd_addr;
  logic                         new_less;
  logic                         cur_ok;

  assign rd_ent      = sism_pkg::entry_t'(rd_raw);
  assign ram_rd_en   = cmd.rd_old | cmd.rd_cursor;
  assign ram_rd_addr = cmd.rd_cursor ? cursor : rd_idx[AW-1:0];

  sism_ram #(
    .WIDTH (sism_pkg::ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (wr_idx[AW-1:0]),
    .wr_data (acc),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (rd_raw)
  );

  // Merge stage: next stream item joins the held entry or pushes it out
  assign feeding   = cmd.feed_new | cmd.feed_old;
  assign feed_ent  = cmd.feed_new ? new_ent : rd_ent;
  assign can_merge = acc_valid && (feed_ent.seq == acc.seq) && (feed_ent.start <= acc.stop);
  assign emit      = feeding && acc_valid && !can_merge;
  assign ram_wr_en = emit | cmd.flush;

  // Ordering: new interval goes before the first greater stored entry
  assign new_less = (new_ent.seq < rd_ent.seq) ||
                    ((new_ent.seq == rd_ent.seq) && (new_ent.start < rd_ent.start));

  // Status towards the controller
  assign cur_ok           = CW'(cursor) < count;
  assign stat.func        = new_func;
  assign stat.range_bad   = new_ent.start > new_ent.stop;
  assign stat.full        = count >= CW'(CAPACITY);
  assign stat.can_advance = (CW'(cursor) + CW'(1)) < count;
  assign stat.rd_more     = rd_idx < old_cnt;
  assign stat.pick_new    = !inserted && (!stat.rd_more || new_less);
  assign stat.out_free    = !out_valid || !out_stall;

  // Captured item, payload only
  always_ff @(posedge clk) begin
    if (cmd.load_new) begin
      new_func      <= func;
      new_ent.seq   <= seq_id;
      new_ent.start <= start_pos;
      new_ent.stop  <= stop_pos;
    end
  end

  // Count, cursor and status
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      cursor   <= '0;
      status_q <= sism_pkg::ST_OK;
    end else begin
      if (cmd.set_status) begin
        status_q <= cmd.status_code;
      end
      if (cmd.cursor_inc) begin
        cursor <= cursor + AW'(1);
      end
      if (cmd.flush) begin
        count <= wr_idx + CW'(1);
      end
    end
  end

  // Rewrite pass indices and held entry
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx    <= '0;
      wr_idx    <= '0;
      old_cnt   <= '0;
      inserted  <= 1'b0;
      acc_valid <= 1'b0;
    end else begin
      if (cmd.pass_init) begin
        rd_idx    <= '0;
        wr_idx    <= '0;
        old_cnt   <= count;
        inserted  <= 1'b0;
        acc_valid <= 1'b0;
      end
      if (cmd.feed_new) begin
        inserted <= 1'b1;
      end
      if (cmd.feed_old) begin
        rd_idx <= rd_idx + CW'(1);
      end
      if (feeding) begin
        acc_valid <= 1'b1;
      end
      if (emit) begin
        wr_idx <= wr_idx + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (feeding) begin
      if (can_merge) begin
        if (acc.stop < feed_ent.stop) begin
          acc.stop <= feed_ent.stop;
        end
      end else begin
        acc <= feed_ent;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status       <= status_q;
      entries_held <= sism_pkg::HELD_W'(count);
      cur_valid    <= cur_ok;
      cur_seq      <= cur_ok ? rd_ent.seq : '0;
      cur_start    <= cur_ok ? rd_ent.start : '0;
      cur_stop     <= cur_ok ? rd_ent.stop : '0;
    end
  end

endmodule

// ----- design/sorted_interval_set_merge_unit.sv -----
// ----------------------------------------------------------------------------
// sorted_interval_set_merge_unit
// Sorted table of inclusive intervals with merge on insert and a read cursor.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): func 0 inserts (seq_id, start_pos,
//   stop_pos), func 1 steps the read cursor. One item is taken at a time;
//   in_stall stays high from acceptance until the result is loaded.
//   Output channel (out_valid / out_stall): one result per item with status,
//   entries_held and the entry at the cursor (zeros when cur_valid is low).
//   An advance or a rejected insert goes from decode straight to the cursor
//   read and the result load. A good insert first runs a rewrite pass over
//   the N stored entries (at most 63, the most an accepted insert can find):
//   the pass reads each stored entry through the single registered read port
//   of the table RAM and streams it through the merge stage. The next item
//   can be taken in the cycle after the result is loaded.
//   The next item is taken while a result still waits in the output register;
//   a stalled receiver holds back the next result only, not the pass.
//   Reset empties the table and sets the cursor to zero; no clearing pass.
// ----------------------------------------------------------------------------
module sorted_interval_set_merge_unit #(
  parameter int CAPACITY = sism_pkg::CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        func,
  input  logic [sism_pkg::SEQ_W-1:0]  seq_id,
  input  logic [sism_pkg::POS_W-1:0]  start_pos,
  input  logic [sism_pkg::POS_W-1:0]  stop_pos,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  status,
  output logic [sism_pkg::HELD_W-1:0] entries_held,
  output logic                        cur_valid,
  output logic [sism_pkg::SEQ_W-1:0]  cur_seq,
  output logic [sism_pkg::POS_W-1:0]  cur_start,
  output logic [sism_pkg::POS_W-1:0]  cur_stop
);

  sism_pkg::cmd_t  cmd;
  sism_pkg::stat_t stat;

  // Sequencer
  sism_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Table, merge stage and result register
  sism_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .func         (func),
    .seq_id       (seq_id),
    .start_pos    (start_pos),
    .stop_pos     (stop_pos),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .entries_held (entries_held),
    .cur_valid    (cur_valid),
    .cur_seq      (cur_seq),
    .cur_start    (cur_start),
    .cur_stop     (cur_stop)
  );

endmodule

// ----- design/sism_checker.sv -----
// ----------------------------------------------------------------------------
// sism_checker
// Port-level checks of the sorted interval set merge unit, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sism_checker #(
  parameter int CAPACITY = sism_pkg::CAPACITY_DEF
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        func,
  input logic [sism_pkg::SEQ_W-1:0]  seq_id,
  input logic [sism_pkg::POS_W-1:0]  start_pos,
  input logic [sism_pkg::POS_W-1:0]  stop_pos,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [1:0]                  status,
  input logic [sism_pkg::HELD_W-1:0] entries_held,
  input logic                        cur_valid,
  input logic [sism_pkg::SEQ_W-1:0]  cur_seq,
  input logic [sism_pkg::POS_W-1:0]  cur_start,
  input logic [sism_pkg::POS_W-1:0]  cur_stop
);

  // A stalled result stays offered
  `ASSERT_CLK(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid, "result dropped while stalled")

  // After reset the block is empty-handed and ready
  `ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !out_valid && !in_stall, "not idle after reset")

  // No cursor, no entry fields
  `ASSERT_CLK(a_invalid_zero, clk, rst, out_valid && !cur_valid |-> cur_seq == '0 && cur_start == '0 && cur_stop == '0, "fields set with invalid cursor")

  // Stored intervals are never reversed
  `ASSERT_CLK(a_entry_order, clk, rst, out_valid && cur_valid |-> cur_start <= cur_stop, "stored interval reversed")

  // A full rejection only when the table really is full
  `ASSERT_CLK(a_full_count, clk, rst, out_valid && status == sism_pkg::ST_FULL |-> entries_held == sism_pkg::HELD_W'(CAPACITY), "full status with room left")

endmodule

bind sorted_interval_set_merge_unit sism_checker #(.CAPACITY(CAPACITY)) u_sism_checker (.*);
